// ----- rtl/ilp_pkg.sv -----
// ----------------------------------------------------------------------------
// ilp_pkg
// Types, character codes and helper functions shared by the integer literal
// parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ilp_pkg;

   localparam int VALUE_BITS = 16;
   localparam int OUT_BITS   = 16;

   localparam logic [7:0] CH_PLUS       = 8'h2b;
   localparam logic [7:0] CH_MINUS      = 8'h2d;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_F    = 8'h66;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_F    = 8'h46;
   localparam logic [7:0] CH_LOWER_X    = 8'h78;
   localparam logic [7:0] CH_UPPER_X    = 8'h58;
   localparam logic [7:0] CH_LOWER_O    = 8'h6f;
   localparam logic [7:0] CH_UPPER_O    = 8'h4f;
   localparam logic [7:0] CH_LOWER_B    = 8'h62;
   localparam logic [7:0] CH_UPPER_B    = 8'h42;

   localparam logic [4:0] DIGIT_INVALID = 5'd31;

   typedef enum logic [2:0] {
      PH_START,
      PH_SIGNED,
      PH_ZERO,
      PH_PREFIX,
      PH_PREFIX_US,
      PH_DIGITS
   } phase_type;

   typedef enum logic [1:0] {
      RC_DEC,
      RC_HEX,
      RC_OCT,
      RC_BIN
   } radix_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] value;
      logic                ok;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      req_payload_type item;
   } stage_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

   typedef struct packed {
      phase_type             phase;
      logic                  negative;
      radix_type             radix_code;
      logic [VALUE_BITS-1:0] accum;
      logic [1:0]            digit_count;
      logic                  all_zero;
      logic                  first_is_zero;
      logic                  underscore_pending;
      logic                  failed;
   } parse_state_type;

   function automatic parse_state_type parse_reset_value();
      parse_state_type s;
      s.phase              = PH_START;
      s.negative           = 1'b0;
      s.radix_code         = RC_DEC;
      s.accum              = '0;
      s.digit_count        = 2'd0;
      s.all_zero           = 1'b1;
      s.first_is_zero      = 1'b0;
      s.underscore_pending = 1'b0;
      s.failed             = 1'b0;
      return s;
   endfunction

   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] d;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = 5'(c - CH_ZERO);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         d = 5'(c - CH_LOWER_A) + 5'd10;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         d = 5'(c - CH_UPPER_A) + 5'd10;
      end else begin
         d = DIGIT_INVALID;
      end
      return d;
   endfunction

   function automatic logic [4:0] radix_of(input radix_type rc);
      logic [4:0] r;
      unique case (rc)
         RC_DEC: r = 5'd10;
         RC_HEX: r = 5'd16;
         RC_OCT: r = 5'd8;
         RC_BIN: r = 5'd2;
         default: r = 5'd10;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/integer_literal_parser.sv -----
// ----------------------------------------------------------------------------
// integer_literal_parser
// Parses a signed integer literal with optional 0x, 0o or 0b prefix and
// underscore separators, one character per word, and returns its value.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake          Payload
//   req_      in          valid / stall      ch[7:0], last
//   rsp_      out         valid / stall      value[15:0], ok
//
// One character is taken per cycle while req_stall is low. A result is
// offered on rsp_ after its final character is accepted and has passed from
// the input register through the combinational update into the result
// register. Reset clears the parse state and both stages. While a result waits
// under rsp_stall, characters that produce no result keep flowing; only a
// final character stalls the input.
`default_nettype none

module integer_literal_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire ilp_pkg::req_payload_type req_payload,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      ilp_pkg::rsp_payload_type rsp_payload
);
   import ilp_pkg::*;

   stage_type  stage;
   result_type result;
   logic       advance;

   assign advance = stage.valid && (!stage.item.last || !rsp_valid || !rsp_stall);

   ilp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .advance     (advance),
      .req_stall   (req_stall),
      .stage       (stage)
   );

   ilp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .stage   (stage),
      .result  (result)
   );

   ilp_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- rtl/ilp_in_stage.sv -----
// ----------------------------------------------------------------------------
// ilp_in_stage
// Input register that holds one accepted character until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_in_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire ilp_pkg::req_payload_type req_payload,
   input  wire logic                    advance,
   output      logic                    req_stall,
   output      ilp_pkg::stage_type      stage
);
   import ilp_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type item_ff;
   logic            load;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_payload;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

`default_nettype wire

// ----- rtl/ilp_parse.sv -----
// ----------------------------------------------------------------------------
// ilp_parse
// Parse state registers and the per-character update, with the result
// formed on the final character of a text.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_parse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire ilp_pkg::stage_type stage,
   output      ilp_pkg::result_type result
);
   import ilp_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type upd;
   logic [7:0]      c;
   logic            is_last;
   logic [4:0]      d;
   logic [4:0]      radix;
   logic            prefix_hit;
   radix_type       prefix_code;
   logic [VALUE_BITS-1:0] scaled;
   logic            good;
   logic [VALUE_BITS-1:0] final_value;

   assign c       = stage.item.ch;
   assign is_last = stage.item.last;
   assign d       = digit_value(c);
   assign radix   = radix_of(state_ff.radix_code);

   always_comb begin
      prefix_hit  = 1'b1;
      prefix_code = RC_DEC;
      if (c == CH_LOWER_X || c == CH_UPPER_X) begin
         prefix_code = RC_HEX;
      end else if (c == CH_LOWER_O || c == CH_UPPER_O) begin
         prefix_code = RC_OCT;
      end else if (c == CH_LOWER_B || c == CH_UPPER_B) begin
         prefix_code = RC_BIN;
      end else begin
         prefix_hit = 1'b0;
      end
   end

   always_comb begin
      unique case (state_ff.radix_code)
         RC_DEC: scaled = (state_ff.accum << 3) + (state_ff.accum << 1);
         RC_HEX: scaled = state_ff.accum << 4;
         RC_OCT: scaled = state_ff.accum << 3;
         RC_BIN: scaled = state_ff.accum << 1;
         default: scaled = state_ff.accum;
      endcase
   end

   always_comb begin
      upd = state_ff;
      priority if (state_ff.failed) begin
         upd = state_ff;
      end else if (state_ff.phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
         upd.negative = (c == CH_MINUS);
         upd.phase    = PH_SIGNED;
      end else if (state_ff.phase == PH_ZERO && prefix_hit) begin
         upd.radix_code    = prefix_code;
         upd.accum         = '0;
         upd.digit_count   = 2'd0;
         upd.all_zero      = 1'b1;
         upd.first_is_zero = 1'b0;
         upd.phase         = PH_PREFIX;
      end else if (c == CH_UNDERSCORE) begin
         priority if (state_ff.phase == PH_PREFIX && !is_last) begin
            upd.phase = PH_PREFIX_US;
         end else if (state_ff.digit_count != 2'd0 && !state_ff.underscore_pending
                      && !is_last) begin
            upd.underscore_pending = 1'b1;
            upd.phase              = PH_DIGITS;
         end else begin
            upd.failed = 1'b1;
         end
      end else if (d >= radix) begin
         upd.failed = 1'b1;
      end else begin
         if (state_ff.digit_count == 2'd0) begin
            upd.first_is_zero = (d == 5'd0);
         end
         if (d != 5'd0) begin
            upd.all_zero = 1'b0;
         end
         upd.accum = scaled + VALUE_BITS'(d);
         if (state_ff.digit_count != 2'd2) begin
            upd.digit_count = state_ff.digit_count + 2'd1;
         end
         upd.underscore_pending = 1'b0;
         if ((state_ff.phase == PH_START || state_ff.phase == PH_SIGNED) && d == 5'd0) begin
            upd.phase = PH_ZERO;
         end else begin
            upd.phase = PH_DIGITS;
         end
      end
   end

   always_comb begin
      good = !upd.failed && !upd.underscore_pending && upd.digit_count != 2'd0;
      if (upd.radix_code == RC_DEC && upd.digit_count == 2'd2 && !upd.all_zero
          && upd.first_is_zero) begin
         good = 1'b0;
      end
      final_value = '0;
      if (good) begin
         final_value = upd.negative ? (VALUE_BITS'(0) - upd.accum) : upd.accum;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = is_last ? parse_reset_value() : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= parse_reset_value();
      end else begin
         state_ff <= state_in;
      end
   end

   assign result.valid         = advance && is_last;
   assign result.payload.value = OUT_BITS'(final_value);
   assign result.payload.ok    = good;

endmodule

`default_nettype wire

// ----- rtl/ilp_out_stage.sv -----
// ----------------------------------------------------------------------------
// ilp_out_stage
// Result register that holds a finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ilp_pkg::result_type  result,
   input  wire logic                 rsp_stall,
   output      logic                 rsp_valid,
   output      ilp_pkg::rsp_payload_type rsp_payload
);
   import ilp_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type payload_ff;

   assign valid_in = result.valid || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         payload_ff <= result.payload;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

`default_nettype wire

// ----- rtl/ilp_checker.sv -----
// ----------------------------------------------------------------------------
// ilp_checker
// Port-level checks for the integer literal parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire ilp_pkg::req_payload_type req_payload,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire ilp_pkg::rsp_payload_type rsp_payload
);
   import ilp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result word changed or vanished.");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("Stalled input word changed or vanished.");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("Input stalled while the result side was free.");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.ok |-> rsp_payload.value == '0)
      else $error("Rejected literal carries a nonzero value.");

endmodule

bind integer_literal_parser ilp_checker u_checker (.*);

`default_nettype wire
